// ===== src/lr_pkg.sv =====
package lr_pkg;

  // Coordinate width is fixed by the payload fields
  localparam int LR_COORD_W   = 10;
  localparam int LR_COLOR_W   = 16;
  // Default fraction width of the minor-axis increment
  localparam int LR_FRAC_BITS = 16;

  // Action codes of the input item
  localparam logic LR_ACT_START   = 1'b0;
  localparam logic LR_ACT_ADVANCE = 1'b1;

  typedef struct packed {
    logic                  action;
    logic [LR_COORD_W-1:0] start_x;
    logic [LR_COORD_W-1:0] start_y;
    logic [LR_COORD_W-1:0] end_x;
    logic [LR_COORD_W-1:0] end_y;
    logic [LR_COLOR_W-1:0] pen_color;
  } lr_in_t;

  typedef struct packed {
    logic [LR_COORD_W-1:0] pixel_x;
    logic [LR_COORD_W-1:0] pixel_y;
    logic [LR_COLOR_W-1:0] pixel_color;
    logic                  last_pixel;
  } lr_out_t;

  // Controller to datapath
  typedef struct packed {
    logic load;     // latch endpoints and color
    logic setup;    // compute deltas, start divider
    logic finish;   // apply sign to quotient, store increment
    logic advance;  // emit one pixel, step the line
  } lr_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic div_last;  // divider performs its final iteration this cycle
    logic last;      // current pixel is the final one of the line
  } lr_stat_t;

endpackage

// ===== src/line_rasterizer_unit.sv =====
// Channel  Ports                          Direction  Moves
// in       in_valid, in_stall, in_item    in         start or advance item
// out      out_valid, out_stall, out_item out        one pixel per transfer
//
// Advance items run at one per cycle while out is not stalled, each pixel landing in an output register.
// A start item holds off the next item until its setup is done: it is latched,
// the deltas are formed, FRACTION_BITS + 1 restoring-divider iterations run
// and the signed increment is stored.
// Synchronous active-low reset returns the engine to idle with no line.
// in_stall rises during setup and while a held pixel is stalled on out.
module line_rasterizer_unit import lr_pkg::*; #(
  parameter int FRACTION_BITS = LR_FRAC_BITS
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  lr_in_t  in_item,
  output logic    out_valid,
  input  logic    out_stall,
  output lr_out_t out_item
);

  lr_cmd_t  cmd;
  lr_stat_t stat;

  lr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_item.action),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  lr_datapath #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_item  (in_item),
    .stat     (stat),
    .out_item (out_item)
  );

`ifndef SYNTHESIS
  // A new pixel only follows an accepted advance
  a_pixel_from_advance: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |->
      $past(in_valid && !in_stall && (in_item.action == LR_ACT_ADVANCE)))
    else $error("pixel appeared without an advance transfer");

  // Input is held off for the whole line setup
  a_stall_in_setup: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.setup |-> in_stall)
    else $error("input taken during line setup");

  // Increment is stored only right after the final divider step
  a_finish_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> $past(stat.div_last))
    else $error("increment stored before division completed");
`endif

endmodule

// ===== src/lr_divider.sv =====
module lr_divider import lr_pkg::*; #(
  parameter int FRACTION_BITS = LR_FRAC_BITS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [LR_COORD_W-1:0]   num,
  input  logic [LR_COORD_W-1:0]   den,
  output logic                    last,
  output logic [FRACTION_BITS:0]  quotient
);

  localparam int CntW = $clog2(FRACTION_BITS + 1);
  localparam int RemW = LR_COORD_W + 1;

  logic                   busy_r, busy_nxt;
  logic [CntW-1:0]        cnt_r, cnt_nxt;
  logic [RemW-1:0]        rem_r, rem_nxt;
  logic [LR_COORD_W-1:0]  den_r, den_nxt;
  logic [FRACTION_BITS:0] quo_r, quo_nxt;

  logic [RemW:0]          diff;
  logic                   ge;
  logic [RemW-1:0]        rem_keep;

  // One restoring step: compare, subtract, shift in a quotient bit
  assign diff     = {1'b0, rem_r} - {2'b00, den_r};
  assign ge       = ~diff[RemW];
  assign rem_keep = ge ? diff[RemW-1:0] : rem_r;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CntW'(FRACTION_BITS);
      rem_nxt  = {1'b0, num};
      den_nxt  = den;
      quo_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt = {rem_keep[LR_COORD_W-1:0], 1'b0};
      quo_nxt = {quo_r[FRACTION_BITS-1:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end
    end
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Operands and partial results
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

  assign last     = busy_r && (cnt_r == '0);
  assign quotient = quo_r;

endmodule

// ===== src/lr_datapath.sv =====
module lr_datapath import lr_pkg::*; #(
  parameter int FRACTION_BITS = LR_FRAC_BITS
) (
  input  logic     clk,
  input  logic     rst_n,
  input  lr_cmd_t  cmd,
  input  lr_in_t   in_item,
  output lr_stat_t stat,
  output lr_out_t  out_item
);

  localparam int CW   = LR_COORD_W;
  localparam int IncW = FRACTION_BITS + 2;
  localparam int AccW = CW + FRACTION_BITS + 2;

  // Latched endpoints and color
  logic [CW-1:0]         org_x_r, org_y_r, end_x_r, end_y_r;
  logic [LR_COLOR_W-1:0] color_r;

  // Line state
  logic                  y_major_r;
  logic                  step_neg_r;
  logic                  minor_neg_r;
  logic                  maj_zero_r;
  logic [CW-1:0]         remain_r;
  logic [CW-1:0]         major_pos_r;
  logic [CW-1:0]         minor_org_r;
  logic signed [AccW-1:0] accum_r;
  logic signed [IncW-1:0] inc_r;
  lr_out_t               out_r;

  // Setup math
  logic signed [CW:0]    dx, dy;
  logic [CW-1:0]         adx, ady;
  logic                  y_major;
  logic [CW-1:0]         maj_mag, min_mag;
  logic                  maj_neg, min_neg;

  // Divider
  logic                  div_last;
  logic [FRACTION_BITS:0] quo;
  logic signed [IncW-1:0] quo_s;

  // Pixel math
  logic signed [AccW-FRACTION_BITS-1:0] moff;
  logic [CW-1:0]         minor_pos;

  assign dx      = $signed({1'b0, end_x_r}) - $signed({1'b0, org_x_r});
  assign dy      = $signed({1'b0, end_y_r}) - $signed({1'b0, org_y_r});
  assign adx     = dx[CW] ? CW'(-dx) : dx[CW-1:0];
  assign ady     = dy[CW] ? CW'(-dy) : dy[CW-1:0];
  // ties go to x
  assign y_major = ady > adx;
  assign maj_mag = y_major ? ady : adx;
  assign min_mag = y_major ? adx : ady;
  assign maj_neg = y_major ? dy[CW] : dx[CW];
  assign min_neg = y_major ? dx[CW] : dy[CW];

  lr_divider #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.setup),
    .num      (min_mag),
    .den      (maj_mag),
    .last     (div_last),
    .quotient (quo)
  );

  // Magnitude quotient, truncated toward zero, as a non-negative signed value; the minor sign is applied on finish
  assign quo_s = $signed({1'b0, quo});

  // Minor coordinate: origin plus floor of the accumulator
  assign moff      = accum_r[AccW-1:FRACTION_BITS];
  assign minor_pos = minor_org_r + moff[CW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      org_x_r     <= '0;
      org_y_r     <= '0;
      end_x_r     <= '0;
      end_y_r     <= '0;
      color_r     <= '0;
      y_major_r   <= 1'b0;
      step_neg_r  <= 1'b0;
      minor_neg_r <= 1'b0;
      maj_zero_r  <= 1'b0;
      remain_r    <= '0;
      major_pos_r <= '0;
      minor_org_r <= '0;
      accum_r     <= '0;
      inc_r       <= '0;
      out_r       <= '0;
    end else begin
      if (cmd.load) begin
        org_x_r <= in_item.start_x;
        org_y_r <= in_item.start_y;
        end_x_r <= in_item.end_x;
        end_y_r <= in_item.end_y;
        color_r <= in_item.pen_color;
      end
      if (cmd.setup) begin
        y_major_r   <= y_major;
        step_neg_r  <= maj_neg;
        minor_neg_r <= min_neg;
        maj_zero_r  <= (maj_mag == '0);
        remain_r    <= maj_mag;
        major_pos_r <= y_major ? org_y_r : org_x_r;
        minor_org_r <= y_major ? org_x_r : org_y_r;
        accum_r     <= '0;
      end
      if (cmd.finish) begin
        if (maj_zero_r) begin
          inc_r <= '0;
        end else begin
          inc_r <= minor_neg_r ? -quo_s : quo_s;
        end
      end
      // Emit the current pixel, then step toward the end point
      if (cmd.advance) begin
        out_r.pixel_x     <= y_major_r ? minor_pos : major_pos_r;
        out_r.pixel_y     <= y_major_r ? major_pos_r : minor_pos;
        out_r.pixel_color <= color_r;
        out_r.last_pixel  <= (remain_r == '0);
        if (remain_r != '0) begin
          remain_r    <= remain_r - 1'b1;
          major_pos_r <= step_neg_r ? major_pos_r - 1'b1 : major_pos_r + 1'b1;
          accum_r     <= accum_r + {{(AccW-IncW){inc_r[IncW-1]}}, inc_r};
        end
      end
    end
  end

  assign stat.div_last = div_last;
  assign stat.last     = (remain_r == '0);
  assign out_item      = out_r;

endmodule

// ===== src/lr_ctrl.sv =====
module lr_ctrl import lr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_action,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  lr_stat_t stat,
  output lr_cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DIVIDE,
    ST_FINISH,
    ST_ACTIVE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   can_take;
  logic   in_xfer;

  // Take an item only while no setup runs and the output slot can be filled
  assign can_take = ((state_r == ST_IDLE) || (state_r == ST_ACTIVE)) &&
                    (!out_valid_r || !out_stall);
  assign in_stall = !can_take;
  assign in_xfer  = in_valid && can_take;

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    case (state_r)
      ST_IDLE: begin
        // an advance with no line is taken and dropped
        if (in_xfer && (in_action == LR_ACT_START)) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (stat.div_last) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
        state_nxt  = ST_ACTIVE;
      end
      ST_ACTIVE: begin
        if (in_xfer) begin
          if (in_action == LR_ACT_START) begin
            cmd.load  = 1'b1;
            state_nxt = ST_SETUP;
          end else begin
            cmd.advance = 1'b1;
            if (stat.last) begin
              state_nxt = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    out_valid_nxt = (out_valid_r && out_stall) || cmd.advance;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule
